/* hw/rtl/rhpd_pkg.sv */
// Shared constants and types for the ratio hysteresis pressure detector.
`timescale 1ns / 1ps

package rhpd_pkg;

	localparam int AMOUNT_BITS = 48;
	localparam int FRAC_BITS   = 16;
	localparam int RATIO_W     = FRAC_BITS + 1;
	localparam int HITS_W      = 8;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = RATIO_W;
	localparam int STEP_W      = $clog2(RATIO_W);

	localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
	// floor(0.01 * 2^FRAC_BITS), widened by one bit for the signed release level
	localparam logic [RATIO_W:0]   ONE_PCT   = (RATIO_W+1)'((64'd1 << FRAC_BITS) / 64'd100);
	// ceil(0.99 * 2^FRAC_BITS)
	localparam logic [RATIO_W-1:0] AT_MAX    =
		RATIO_W'(((64'd99 << FRAC_BITS) + 64'd99) / 64'd100);
	localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(FRAC_BITS);
	localparam logic [HITS_W-1:0]  HITS_MAX  = {HITS_W{1'b1}};

	localparam logic [RATIO_W-1:0] THRESHOLD_RST  = RATIO_W'(62259);
	localparam logic [RATIO_W-1:0] HYSTERESIS_RST = RATIO_W'(3277);
	localparam logic [HITS_W-1:0]  ACTIVATE_RST   = HITS_W'(3);
	localparam logic [HITS_W-1:0]  RELEASE_RST    = HITS_W'(3);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD  = CFG_IDX_W'(0),
		CFG_HYSTERESIS = CFG_IDX_W'(1),
		CFG_ACTIVATE   = CFG_IDX_W'(2),
		CFG_RELEASE    = CFG_IDX_W'(3)
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_UPDATE
	} rhpd_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RANGE,
		DIV_STEP
	} div_state_t;

	typedef struct packed {
		logic               done;
		logic [RATIO_W-1:0] ratio;
	} div_res_t;

endpackage

/* hw/rtl/rhpd_if.sv */
// Channel interfaces: sample/resize requests, results and register writes.
`timescale 1ns / 1ps

interface rhpd_req_if;
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic [rhpd_pkg::AMOUNT_BITS-1:0] used_amount;
	logic [rhpd_pkg::AMOUNT_BITS-1:0] limit_amount;

	modport source (output valid, command, used_amount, limit_amount, input ready);
	modport sink (input valid, command, used_amount, limit_amount, output ready);
endinterface

interface rhpd_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         signal_active;
	logic [rhpd_pkg::RATIO_W-1:0] signal_level;
	logic                         at_max_capacity;
	logic                         pressure_driven;
	logic                         sample_skipped;

	modport source (output valid, signal_active, signal_level, at_max_capacity,
		pressure_driven, sample_skipped, input ready);
	modport sink (input valid, signal_active, signal_level, at_max_capacity,
		pressure_driven, sample_skipped, output ready);
endinterface

interface rhpd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rhpd_pkg::CFG_IDX_W-1:0]  index;
	logic [rhpd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/rhpd_div.sv */
// Bit-serial ratio divider: one shared subtractor, range check then one quotient bit per cycle.
`timescale 1ns / 1ps

module rhpd_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rhpd_pkg::AMOUNT_BITS-1:0] used,
	input  logic [rhpd_pkg::AMOUNT_BITS-1:0] limit,
	output rhpd_pkg::div_res_t               res
);

	rhpd_pkg::div_state_t state_q, state_d;

	logic [rhpd_pkg::AMOUNT_BITS:0]   rem_q;
	logic [rhpd_pkg::AMOUNT_BITS-1:0] lim_q;
	logic [rhpd_pkg::RATIO_W-1:0]     quo_q;
	logic [rhpd_pkg::STEP_W-1:0]      cnt_q;
	logic                             done_q;

	logic [rhpd_pkg::AMOUNT_BITS:0]   sub_b;
	logic [rhpd_pkg::AMOUNT_BITS+1:0] diff;
	logic                             ge;
	logic                             finish;

	// range check subtracts 2*limit; a step subtracts limit
	always_comb begin
		if (state_q == rhpd_pkg::DIV_RANGE) begin
			sub_b = {lim_q, 1'b0};
		end else begin
			sub_b = {1'b0, lim_q};
		end
		diff = {1'b0, rem_q} - {1'b0, sub_b};
		ge   = ~diff[rhpd_pkg::AMOUNT_BITS+1];
	end

	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		case (state_q)
			rhpd_pkg::DIV_IDLE: begin
				if (start) state_d = rhpd_pkg::DIV_RANGE;
			end
			rhpd_pkg::DIV_RANGE: begin
				if (ge) begin
					state_d = rhpd_pkg::DIV_IDLE;
					finish  = 1'b1;
				end else begin
					state_d = rhpd_pkg::DIV_STEP;
				end
			end
			rhpd_pkg::DIV_STEP: begin
				if (cnt_q == rhpd_pkg::STEP_LAST) begin
					state_d = rhpd_pkg::DIV_IDLE;
					finish  = 1'b1;
				end
			end
			default: state_d = rhpd_pkg::DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rhpd_pkg::DIV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rhpd_pkg::DIV_IDLE: begin
				if (start) begin
					rem_q <= {1'b0, used};
					lim_q <= limit;
					quo_q <= '0;
					cnt_q <= '0;
				end
			end
			rhpd_pkg::DIV_RANGE: begin
				if (ge) quo_q <= rhpd_pkg::RATIO_MAX;
			end
			rhpd_pkg::DIV_STEP: begin
				quo_q <= {quo_q[rhpd_pkg::RATIO_W-2:0], ge};
				// remainder stays below limit, so the doubled value fits
				if (ge) begin
					rem_q <= {diff[rhpd_pkg::AMOUNT_BITS-1:0], 1'b0};
				end else begin
					rem_q <= {rem_q[rhpd_pkg::AMOUNT_BITS-1:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res.done  = done_q;
	assign res.ratio = quo_q;

endmodule

/* hw/rtl/ratio_hysteresis_pressure_detector_top.sv */
// Top level of the ratio hysteresis pressure detector.
`timescale 1ns / 1ps

// Usage: req carries one word per sample (command 0, used/limit amounts) or per
// resize event (command 1). rsp returns exactly one word per req word: the
// pressure signal, the held ratio (16 fraction bits), the at-max flag, the
// sticky pressure latch on resize and a skip flag for a zero limit. cfg writes
// the threshold, hysteresis and hit counts; it is always ready and should be
// used only while no request is in flight.
// Flow: req.ready is high only while idle, so a new word is taken only after
// the last one has left the update step. A sample with a nonzero limit runs the
// bit-serial divider: a range check, then one subtract/shift step per quotient
// bit on the shared 49-bit subtractor, then the update step that registers the
// result. A ratio that saturates (used >= 2*limit) skips the shift steps;
// resize events and zero-limit samples go from idle straight to the update step.
// A finished word sits in the output register; a stalled rsp holds it and the
// next item waits in the update step until that register drains.
// Reset clears all detector state and loads the default register values.
module ratio_hysteresis_pressure_detector_top (
	input  logic          clk,
	input  logic          arst_n,
	rhpd_req_if.sink      req,
	rhpd_rsp_if.source    rsp,
	rhpd_cfg_if.sink      cfg
);

	rhpd_pkg::rhpd_state_t state_q, state_d;

	logic [rhpd_pkg::RATIO_W-1:0] threshold_q;
	logic [rhpd_pkg::RATIO_W-1:0] hysteresis_q;
	logic [rhpd_pkg::HITS_W-1:0]  activate_q;
	logic [rhpd_pkg::HITS_W-1:0]  release_q;

	logic [rhpd_pkg::HITS_W-1:0]  high_run_q;
	logic [rhpd_pkg::HITS_W-1:0]  low_run_q;
	logic                         active_q;
	logic [rhpd_pkg::RATIO_W-1:0] held_q;
	logic                         seen_q;
	logic                         max_q;

	logic                         cmd_q;
	logic                         skip_q;

	logic                         out_valid_q;
	logic                         out_active_q;
	logic [rhpd_pkg::RATIO_W-1:0] out_level_q;
	logic                         out_max_q;
	logic                         out_driven_q;
	logic                         out_skipped_q;

	logic                         accept;
	logic                         limit_zero;
	logic                         div_start;
	logic                         upd_fire;
	rhpd_pkg::div_res_t           div_res;

	logic [rhpd_pkg::HITS_W-1:0]  high_inc;
	logic [rhpd_pkg::HITS_W-1:0]  low_inc;
	logic signed [rhpd_pkg::RATIO_W:0] rel_raw;
	logic [rhpd_pkg::RATIO_W:0]   rel_level;
	logic                         q_high;
	logic                         q_low;

	logic [rhpd_pkg::HITS_W-1:0]  high_run_d;
	logic [rhpd_pkg::HITS_W-1:0]  low_run_d;
	logic                         active_d;
	logic [rhpd_pkg::RATIO_W-1:0] held_d;
	logic                         seen_d;
	logic                         max_d;
	logic                         driven_d;

	assign req.ready  = (state_q == rhpd_pkg::ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign limit_zero = (req.limit_amount == '0);
	assign div_start  = accept && !req.command && !limit_zero;
	assign upd_fire   = (state_q == rhpd_pkg::ST_UPDATE) && (!out_valid_q || rsp.ready);
	assign cfg.ready  = 1'b1;

	rhpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.used   (req.used_amount),
		.limit  (req.limit_amount),
		.res    (div_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rhpd_pkg::ST_IDLE: begin
				if (accept) begin
					if (div_start) begin
						state_d = rhpd_pkg::ST_DIVIDE;
					end else begin
						state_d = rhpd_pkg::ST_UPDATE;
					end
				end
			end
			rhpd_pkg::ST_DIVIDE: begin
				if (div_res.done) state_d = rhpd_pkg::ST_UPDATE;
			end
			rhpd_pkg::ST_UPDATE: begin
				if (upd_fire) state_d = rhpd_pkg::ST_IDLE;
			end
			default: state_d = rhpd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rhpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.command;
			skip_q <= !req.command && limit_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= rhpd_pkg::THRESHOLD_RST;
			hysteresis_q <= rhpd_pkg::HYSTERESIS_RST;
			activate_q   <= rhpd_pkg::ACTIVATE_RST;
			release_q    <= rhpd_pkg::RELEASE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				rhpd_pkg::CFG_THRESHOLD:  threshold_q  <= cfg.data;
				rhpd_pkg::CFG_HYSTERESIS: hysteresis_q <= cfg.data;
				rhpd_pkg::CFG_ACTIVATE:   activate_q   <= cfg.data[rhpd_pkg::HITS_W-1:0];
				rhpd_pkg::CFG_RELEASE:    release_q    <= cfg.data[rhpd_pkg::HITS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// release level = max(threshold - hysteresis, one percent)
	always_comb begin
		rel_raw = $signed({1'b0, threshold_q}) - $signed({1'b0, hysteresis_q});
		if (rel_raw < $signed(rhpd_pkg::ONE_PCT)) begin
			rel_level = rhpd_pkg::ONE_PCT;
		end else begin
			rel_level = rel_raw;
		end
		q_high   = (div_res.ratio >= threshold_q);
		q_low    = ({1'b0, div_res.ratio} < rel_level);
		high_inc = (high_run_q == rhpd_pkg::HITS_MAX) ? high_run_q : high_run_q + 1'b1;
		low_inc  = (low_run_q == rhpd_pkg::HITS_MAX) ? low_run_q : low_run_q + 1'b1;
	end

	always_comb begin
		high_run_d = high_run_q;
		low_run_d  = low_run_q;
		active_d   = active_q;
		held_d     = held_q;
		seen_d     = seen_q;
		max_d      = max_q;
		driven_d   = 1'b0;
		if (cmd_q) begin
			driven_d   = seen_q;
			high_run_d = '0;
			low_run_d  = '0;
			active_d   = 1'b0;
			held_d     = '0;
			seen_d     = 1'b0;
			max_d      = 1'b0;
		end else if (!skip_q) begin
			if (q_high) begin
				high_run_d = high_inc;
				low_run_d  = '0;
				if (high_inc >= activate_q) begin
					active_d = 1'b1;
					held_d   = div_res.ratio;
					seen_d   = 1'b1;
				end
			end else if (q_low) begin
				low_run_d  = low_inc;
				high_run_d = '0;
				if (active_q && (low_inc >= release_q)) begin
					active_d  = 1'b0;
					held_d    = '0;
					low_run_d = '0;
				end
			end else begin
				high_run_d = '0;
				low_run_d  = '0;
			end
			max_d = active_d && (div_res.ratio >= rhpd_pkg::AT_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_run_q <= '0;
			low_run_q  <= '0;
			active_q   <= 1'b0;
			held_q     <= '0;
			seen_q     <= 1'b0;
			max_q      <= 1'b0;
		end else if (upd_fire) begin
			high_run_q <= high_run_d;
			low_run_q  <= low_run_d;
			active_q   <= active_d;
			held_q     <= held_d;
			seen_q     <= seen_d;
			max_q      <= max_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			out_active_q  <= active_d;
			out_level_q   <= active_d ? held_d : '0;
			out_max_q     <= max_d;
			out_driven_q  <= driven_d;
			out_skipped_q <= skip_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.signal_active   = out_active_q;
	assign rsp.signal_level    = out_level_q;
	assign rsp.at_max_capacity = out_max_q;
	assign rsp.pressure_driven = out_driven_q;
	assign rsp.sample_skipped  = out_skipped_q;

endmodule

/* hw/rtl/rhpd_checker.sv */
// Port-level checks for the pressure detector, bound to the top level.
`timescale 1ns / 1ps

module rhpd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         signal_active,
	input logic [rhpd_pkg::RATIO_W-1:0] signal_level,
	input logic                         at_max_capacity,
	input logic                         pressure_driven,
	input logic                         sample_skipped
);

	// one word at a time: an accepted word closes the request side
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("req still ready right after an accepted word");

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("rsp word dropped while stalled");

	a_level_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !signal_active) |-> (signal_level == '0) && !at_max_capacity)
		else $error("level or at-max reported while signal inactive");

	a_resize_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && pressure_driven) |-> !signal_active && !sample_skipped)
		else $error("pressure latch reported outside a resize result");

endmodule

bind ratio_hysteresis_pressure_detector_top rhpd_checker u_rhpd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.signal_active   (rsp.signal_active),
	.signal_level    (rsp.signal_level),
	.at_max_capacity (rsp.at_max_capacity),
	.pressure_driven (rsp.pressure_driven),
	.sample_skipped  (rsp.sample_skipped)
);
